// ===== rtl/sdht_pkg.sv =====
package sdht_pkg;

   localparam int AXES_DEFAULT = 3;

   localparam int ADDR_WIDTH = 3;
   localparam int DATA_WIDTH = 32;
   localparam int POS_WIDTH = 32;

   // Function codes of an input item.
   localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
   localparam logic [1:0] FUNC_ENTER   = 2'd1;
   localparam logic [1:0] FUNC_EXIT    = 2'd2;
   localparam logic [1:0] FUNC_RESTART = 2'd3;

   // Register indexes, taken from address bit 2.
   localparam logic REG_STEP_TIME_LIMIT = 1'b0;
   localparam logic REG_MIN_TRAVEL      = 1'b1;

   localparam logic [15:0] STEP_TIME_LIMIT_RESET = 16'd430;
   localparam logic [19:0] MIN_TRAVEL_RESET      = 20'd128;

   localparam logic [31:0] LOAD_MASK      = 32'h0000_03ff;
   localparam logic [19:0] STEP_HIGH_BITS = 20'hf_0000;
   localparam logic [15:0] STEP_SATURATED = 16'hffff;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         axis;
      logic signed [31:0] position;
      logic [19:0]        step_time_raw;
      logic [31:0]        status_word;
   } req_type;

   typedef struct packed {
      logic [2:0] stalled_flags;
      logic [2:0] homing_mask;
      logic       homing_active;
      logic       new_stall;
   } rsp_type;

   typedef struct packed {
      logic [15:0] step_time_limit;
      logic [19:0] min_travel;
   } cfg_type;

endpackage

// ===== rtl/stall_detect_homing_tracker_core.sv =====
// An accepted item passes through the execute stage and then the result register, whose
// output is held until the result side takes it.
// Throughput: one item per cycle while results are taken; the start-position RAM is
// read when an item enters and written back when it commits, with a one-entry
// forward path covering a read that meets a write to the same axis.
// Reset clears all stall and armed bits and marks every start position as zero;
// the registers return to 430 and 128. No clearing pass is needed.
module stall_detect_homing_tracker_core #(
   parameter int AXES = sdht_pkg::AXES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sdht_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sdht_pkg::rsp_type                rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sdht_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [sdht_pkg::DATA_WIDTH-1:0]  csr_pwdata,
   output logic [sdht_pkg::DATA_WIDTH-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int PW = (AXES > 3) ? AXES : 3;
   localparam int PWIDTH = sdht_pkg::POS_WIDTH;

   sdht_pkg::cfg_type cfg;

   // Execute stage, holding the item whose start position is being read.
   logic              s1_valid_ff, s1_valid_in;
   sdht_pkg::req_type s1_item_ff;

   logic [AXES-1:0]   stall_ff, stall_in;
   logic [AXES-1:0]   armed_ff, armed_in;
   logic [AXES-1:0]   written_ff, written_in;

   logic              fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]     fwd_addr_ff;
   logic [PWIDTH-1:0] fwd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   sdht_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              commit;
   logic [AW-1:0]     s1_addr;
   logic              axis_ok;
   logic [PWIDTH-1:0] ram_rdata;
   logic [PWIDTH-1:0] start_pos;
   logic [PWIDTH-1:0] diff;
   logic [PWIDTH-1:0] travel;
   logic [15:0]       step_time;
   logic              load_zero;
   logic              cond_met;
   logic              hit;
   logic              wr_en;
   logic [PW-1:0]     stall_pad;
   logic [PW-1:0]     armed_pad;

   sdht_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign commit = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || commit;
   assign accept = req_valid && req_ready;

   assign s1_addr = AW'(s1_item_ff.axis);
   assign axis_ok = {30'd0, s1_item_ff.axis} < 32'(AXES);

   sdht_ram #(
      .WIDTH (PWIDTH),
      .DEPTH (AXES)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (s1_item_ff.position),
      .rd_en   (accept),
      .rd_addr (AW'(req_payload.axis)),
      .rd_data (ram_rdata)
   );

   // The forward register always holds the latest value written to its axis,
   // so it also covers a read taken at the same edge as that write.
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_addr) begin
         start_pos = fwd_data_ff;
      end else if (written_ff[s1_addr]) begin
         start_pos = ram_rdata;
      end else begin
         start_pos = '0;
      end
   end

   assign diff = s1_item_ff.position - start_pos;
   assign travel = diff[PWIDTH-1] ? (~diff + 32'd1) : diff;
   assign step_time = ((s1_item_ff.step_time_raw & sdht_pkg::STEP_HIGH_BITS) != 20'd0)
                      ? sdht_pkg::STEP_SATURATED : s1_item_ff.step_time_raw[15:0];
   assign load_zero = (s1_item_ff.status_word & sdht_pkg::LOAD_MASK) == 32'd0;
   assign cond_met = (step_time < cfg.step_time_limit) &&
                     (travel > {12'd0, cfg.min_travel}) && load_zero;

   always_comb begin
      stall_in = stall_ff;
      armed_in = armed_ff;
      written_in = written_ff;
      hit = 1'b0;
      wr_en = 1'b0;
      if (commit) begin
         case (s1_item_ff.func)
            sdht_pkg::FUNC_SAMPLE: begin
               if (axis_ok && armed_ff[s1_addr] && !stall_ff[s1_addr] && cond_met) begin
                  stall_in[s1_addr] = 1'b1;
                  hit = 1'b1;
               end
            end
            sdht_pkg::FUNC_ENTER, sdht_pkg::FUNC_RESTART: begin
               if (axis_ok) begin
                  wr_en = 1'b1;
                  written_in[s1_addr] = 1'b1;
                  stall_in[s1_addr] = 1'b0;
                  if (s1_item_ff.func == sdht_pkg::FUNC_ENTER) begin
                     armed_in[s1_addr] = 1'b1;
                  end
               end
            end
            sdht_pkg::FUNC_EXIT: begin
               if (armed_ff != '0) begin
                  stall_in = '0;
                  armed_in = '0;
               end
            end
            default: begin
               stall_in = stall_ff;
            end
         endcase
      end
   end

   assign stall_pad = PW'(stall_in);
   assign armed_pad = PW'(armed_in);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.stalled_flags = stall_pad[2:0];
         rsp_data_in.homing_mask = armed_pad[2:0];
         rsp_data_in.homing_active = armed_in != '0;
         rsp_data_in.new_stall = hit;
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !commit);
   assign fwd_valid_in = fwd_valid_ff || wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         stall_ff <= '0;
         armed_ff <= '0;
         written_ff <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         stall_ff <= stall_in;
         armed_ff <= armed_in;
         written_ff <= written_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_payload;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= s1_item_ff.position;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // A stalled axis is always an armed axis.
   assert property (@(posedge clock) disable iff (reset)
      (stall_ff & ~armed_ff) == '0)
      else $error("stall bit set on an unarmed axis");

   // A latched stall shows up in the state after the commit.
   assert property (@(posedge clock) disable iff (reset)
      commit && hit |=> stall_ff != '0)
      else $error("new stall not recorded");

   assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && rsp_data_ff.homing_active == (armed_ff != '0))
      else $error("result homing_active disagrees with the armed bits");

   // A full execute stage facing a blocked result register takes no item.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready && !commit)
      else $error("item taken while the pipeline is blocked");

endmodule

// ===== rtl/sdht_ram.sv =====
module sdht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 3
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sdht_csr.sv =====
module sdht_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sdht_pkg::ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [sdht_pkg::DATA_WIDTH-1:0]       csr_pwdata,
   output logic [sdht_pkg::DATA_WIDTH-1:0]       csr_prdata,
   output logic                                  csr_pready,
   output sdht_pkg::cfg_type                     cfg
);

   sdht_pkg::cfg_type cfg_ff;
   sdht_pkg::cfg_type cfg_in;
   logic              write_en;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_paddr[2])
            sdht_pkg::REG_STEP_TIME_LIMIT: cfg_in.step_time_limit = csr_pwdata[15:0];
            sdht_pkg::REG_MIN_TRAVEL:      cfg_in.min_travel = csr_pwdata[19:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sdht_pkg::REG_STEP_TIME_LIMIT: csr_prdata = {16'd0, cfg_ff.step_time_limit};
         sdht_pkg::REG_MIN_TRAVEL:      csr_prdata = {12'd0, cfg_ff.min_travel};
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_time_limit <= sdht_pkg::STEP_TIME_LIMIT_RESET;
         cfg_ff.min_travel <= sdht_pkg::MIN_TRAVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sdht_pkg::*;

   localparam int LONG_HOLD = 200;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_HALF = 115;

   // Predicts the stall and homing flags from every accepted item and checks each result
   // against the oldest prediction.
   class homing_flag_tracker;
      bit [2:0]  stalled;
      bit [2:0]  armed;
      bit [31:0] start_pos [AXES_DEFAULT];
      bit [15:0] step_limit = STEP_TIME_LIMIT_RESET;
      bit [19:0] travel_min = MIN_TRAVEL_RESET;
      rsp_type   expected_flags [$];
      int        mismatches;

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
         end
      endfunction

      function void note_item(req_type it);
         rsp_type   exp;
         bit [15:0] step;
         bit [31:0] diff;
         bit [31:0] travel;
         bit        hit;
         bit        in_range;
         hit = 1'b0;
         in_range = (it.axis < AXES_DEFAULT);
         case (it.func)
            FUNC_SAMPLE: begin
               if (in_range && armed[it.axis] && !stalled[it.axis]) begin
                  step = ((it.step_time_raw & STEP_HIGH_BITS) != 0) ? STEP_SATURATED
                                                                    : it.step_time_raw[15:0];
                  diff = it.position - start_pos[it.axis];
                  // The magnitude of the most negative difference stays 0x80000000.
                  travel = diff[31] ? -diff : diff;
                  if (step < step_limit && travel > travel_min &&
                      (it.status_word & LOAD_MASK) == 0) begin
                     stalled[it.axis] = 1'b1;
                     hit = 1'b1;
                  end
               end
            end
            FUNC_ENTER, FUNC_RESTART: begin
               if (in_range) begin
                  if (it.func == FUNC_ENTER) begin
                     armed[it.axis] = 1'b1;
                  end
                  start_pos[it.axis] = it.position;
                  stalled[it.axis] = 1'b0;
               end
            end
            FUNC_EXIT: begin
               if (armed != 0) begin
                  armed = '0;
                  stalled = '0;
               end
            end
         endcase
         exp.stalled_flags = stalled;
         exp.homing_mask = armed;
         exp.homing_active = |armed;
         exp.new_stall = hit;
         expected_flags.push_back(exp);
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (expected_flags.size() == 0) begin
            flag($sformatf("unexpected result: stalled=%b mask=%b active=%b new=%b",
                           got.stalled_flags, got.homing_mask, got.homing_active,
                           got.new_stall));
            return;
         end
         exp = expected_flags.pop_front();
         if (got.stalled_flags !== exp.stalled_flags || got.homing_mask !== exp.homing_mask ||
             got.homing_active !== exp.homing_active || got.new_stall !== exp.new_stall) begin
            flag($sformatf({"result mismatch: expected stalled=%b mask=%b active=%b new=%b,",
                            " got stalled=%b mask=%b active=%b new=%b"},
                           exp.stalled_flags, exp.homing_mask, exp.homing_active,
                           exp.new_stall, got.stalled_flags, got.homing_mask,
                           got.homing_active, got.new_stall));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [DATA_WIDTH-1:0] csr_prdata;
   logic                  csr_pready;

   homing_flag_tracker sb = new();

   int        send_idle_pct = 31;
   int        recv_idle_pct = 59;
   int        hold_requests = 0;
   int        holds_served = 0;
   int        hold_left = 0;
   bit [31:0] origin [4];

   stall_detect_homing_tracker_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAIL stall_detect_homing_tracker_core");
      $finish;
   end

   // Result-side backpressure; a long hold is started whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_item(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_payload);
         end
      end
   end

   function automatic req_type build_req(logic [1:0] func, logic [1:0] axis,
                                         logic [31:0] position, logic [19:0] raw,
                                         logic [31:0] status);
      req_type it;
      it.func = func;
      it.axis = axis;
      it.position = position;
      it.step_time_raw = raw;
      it.status_word = status;
      return it;
   endfunction

   function automatic req_type random_req();
      return build_req(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom,
                       20'($urandom), $urandom);
   endfunction

   // A sample aimed at the stall boundaries of the current settings.
   function automatic req_type make_sample(logic [1:0] axis);
      bit [19:0] raw;
      bit [31:0] travel;
      bit [31:0] status;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 60 && sb.step_limit != 0) begin
         raw = 20'($urandom_range(sb.step_limit - 1));
      end else if (pick < 75) begin
         raw = {4'h0, sb.step_limit};
      end else if (pick < 90) begin
         raw = {4'($urandom_range(1, 15)), 16'($urandom)};
      end else begin
         raw = 20'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
         travel = sb.travel_min + 1 + $urandom_range(50);
      end else if (pick < 65) begin
         travel = sb.travel_min;
      end else if (pick < 75) begin
         travel = 32'h8000_0000;
      end else begin
         travel = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
         status = $urandom & ~LOAD_MASK;
      end else if (pick < 85) begin
         status = ($urandom & ~LOAD_MASK) | (32'h1 << $urandom_range(9));
      end else begin
         status = $urandom;
      end
      return build_req(FUNC_SAMPLE, axis,
                       $urandom_range(1) ? origin[axis] + travel : origin[axis] - travel,
                       raw, status);
   endfunction

   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (it.func == FUNC_ENTER || it.func == FUNC_RESTART) begin
         origin[it.axis] = it.position;
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // The first edge lets the scoreboard note the last accepted item before the queue is read.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_flags.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes a register, then reads it back through the same port.
   task automatic csr_write(input logic idx, input logic [31:0] value);
      logic [31:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_STEP_TIME_LIMIT) begin
         sb.step_limit = value[15:0];
      end else begin
         sb.travel_min = value[19:0];
      end
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         sb.flag($sformatf("register %0d read back %h, expected %h", idx, readback, value));
      end
   endtask

   // Mostly homing runs (arm, probe, exit) with random content, the rest plain noise.
   task automatic random_traffic(input int n_items);
      int         sent;
      logic [1:0] axis;
      int         pick;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 70) begin
            repeat ($urandom_range(1, 3)) begin
               send_item(build_req(FUNC_ENTER, 2'($urandom_range(2)), $urandom,
                                   20'($urandom), $urandom));
               sent++;
            end
            repeat ($urandom_range(3, 12)) begin
               pick = $urandom_range(99);
               axis = 2'($urandom_range(2));
               if (pick < 75) begin
                  send_item(make_sample(axis));
               end else if (pick < 85) begin
                  send_item(build_req(FUNC_RESTART, axis, $urandom, 20'($urandom), $urandom));
               end else if (pick < 92) begin
                  send_item(build_req(FUNC_ENTER, 2'($urandom_range(3)), $urandom,
                                      20'($urandom), $urandom));
               end else begin
                  send_item(random_req());
               end
               sent++;
            end
            if ($urandom_range(99) < 80) begin
               send_item(build_req(FUNC_EXIT, 2'($urandom_range(3)), $urandom,
                                   20'($urandom), $urandom));
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_item($urandom_range(3) == 0 ? make_sample(2'($urandom_range(3)))
                                                : random_req());
               sent++;
            end
         end
      end
   endtask

   bit [15:0] phase_limit [PHASES] = '{16'd2000, 16'd0, 16'hffff, 16'hffff, 16'd1, 16'd0,
                                      16'd0};
   bit [19:0] phase_travel [PHASES] = '{20'd5000, 20'd0, 20'hfffff, 20'd0, 20'hfffff, 20'd0,
                                       20'd0};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(REG_STEP_TIME_LIMIT, 32'(STEP_TIME_LIMIT_RESET));
      csr_write(REG_MIN_TRAVEL, 32'(MIN_TRAVEL_RESET));

      // Idle behavior, the travel and step-time boundaries and the out-of-range axis.
      send_item(build_req(FUNC_SAMPLE, 2'd0, 32'd500, 20'd0, 32'd0));
      send_item(build_req(FUNC_EXIT, 2'd0, 32'd0, 20'd0, 32'd0));
      send_item(build_req(FUNC_ENTER, 2'd3, 32'd1, 20'd0, 32'd0));
      send_item(build_req(FUNC_RESTART, 2'd1, 32'h7fff_ffff, 20'hfffff, 32'hffff_ffff));
      send_item(build_req(FUNC_ENTER, 2'd0, 32'd0, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd0, 32'd129, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd0, 32'd129, 20'd0, 32'd0));
      send_item(build_req(FUNC_ENTER, 2'd2, 32'h8000_0000, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd2, 32'd0, 20'hf_0000, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd2, 32'd0, 20'd429, 32'hffff_fc00));
      send_item(build_req(FUNC_ENTER, 2'd1, -32'sd5, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd1, 32'd123, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd1, -32'sd134, 20'd430, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd1, -32'sd134, 20'd429, 32'd1));
      send_item(build_req(FUNC_SAMPLE, 2'd1, -32'sd134, 20'h1_0000, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd3, 32'h7fff_0000, 20'd0, 32'd0));
      send_item(build_req(FUNC_RESTART, 2'd0, 32'd100, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd0, 32'd229, 20'd0, 32'd0));
      send_item(build_req(FUNC_RESTART, 2'd3, 32'd7, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd1, -32'sd134, 20'd0, 32'h0000_0400));
      send_item(build_req(FUNC_EXIT, 2'd3, 32'hffff_ffff, 20'hfffff, 32'hffff_ffff));
      send_item(build_req(FUNC_EXIT, 2'd0, 32'd0, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd0, 32'hffff_ffff, 20'hfffff, 32'hffff_ffff));
      send_item(build_req(FUNC_ENTER, 2'd1, 32'h7fff_ffff, 20'd0, 32'd0));
      send_item(build_req(FUNC_SAMPLE, 2'd1, 32'h8000_0000, 20'd0, 32'd0));

      phase_limit[5] = 16'($urandom_range(200, 5000));
      phase_travel[5] = 20'($urandom_range(3000));
      phase_limit[6] = 16'($urandom);
      phase_travel[6] = 20'($urandom);
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         if (phase < 2) begin
            send_idle_pct = 31;
            recv_idle_pct = 59;
         end else if (phase < 4) begin
            send_idle_pct = 59;
            recv_idle_pct = 31;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         csr_write(REG_STEP_TIME_LIMIT, 32'(phase_limit[phase]));
         csr_write(REG_MIN_TRAVEL, 32'(phase_travel[phase]));
         random_traffic(ITEMS_PER_HALF);
         if (phase == 1) begin
            // The result side stops while items keep coming, so the input must stall.
            hold_requests++;
         end else if (phase == 3) begin
            wait_idle();
         end
         random_traffic(ITEMS_PER_HALF);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_flags.size() == 0) begin
         $display("PASS stall_detect_homing_tracker_core");
      end else begin
         $display("FAIL stall_detect_homing_tracker_core");
      end
      $finish;
   end

endmodule
